### rtl/core/dcfb_pkg.sv
// types, constants, microcode table and crc step for the drive command frame builder
package dcfb_pkg;

	localparam int ADDR_W = 5;

	localparam logic [1:0] KIND_SPEED = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [7:0]  STATION_ADDR = 8'h01;
	localparam logic [7:0]  CODE_SPEED   = 8'hEA;
	localparam logic [7:0]  CODE_READ    = 8'h43;
	localparam logic [7:0]  CODE_WRITE   = 8'h44;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;

	// byte sources
	localparam logic [3:0] SRC_STATION = 4'd0;
	localparam logic [3:0] SRC_CODE_RW = 4'd1;
	localparam logic [3:0] SRC_CODE_SP = 4'd2;
	localparam logic [3:0] SRC_W1_HI   = 4'd3;
	localparam logic [3:0] SRC_W1_LO   = 4'd4;
	localparam logic [3:0] SRC_W2_HI   = 4'd5;
	localparam logic [3:0] SRC_W2_LO   = 4'd6;
	localparam logic [3:0] SRC_D1_HI   = 4'd7;
	localparam logic [3:0] SRC_D1_LO   = 4'd8;
	localparam logic [3:0] SRC_D2_HI   = 4'd9;
	localparam logic [3:0] SRC_D2_LO   = 4'd10;
	localparam logic [3:0] SRC_CRC_LO  = 4'd11;
	localparam logic [3:0] SRC_CRC_HI  = 4'd12;

	// jump conditions
	localparam logic [1:0] COND_NONE      = 2'd0;
	localparam logic [1:0] COND_SPEED     = 2'd1;
	localparam logic [1:0] COND_NOT_WRITE = 2'd2;
	localparam logic [1:0] COND_ALWAYS    = 2'd3;

	localparam logic [ADDR_W-1:0] ADDR_CRC   = 5'd10;
	localparam logic [ADDR_W-1:0] ADDR_SPEED = 5'd12;
	localparam logic [ADDR_W-1:0] ADDR_LAST  = 5'd16;

	typedef struct packed {
		logic [3:0]        src;
		logic              crc_upd;
		logic              last;
		logic [1:0]        cond;
		logic [ADDR_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic is_speed;
		logic is_write;
	} stat_t;

	function automatic ctl_t ucode_rom(input logic [ADDR_W-1:0] addr);
		ctl_t w;
		w = '{src: SRC_CRC_HI, crc_upd: 1'b0, last: 1'b1, cond: COND_NONE, target: '0};
		unique case (addr)
			5'd0:  w = '{SRC_STATION, 1'b1, 1'b0, COND_SPEED, ADDR_SPEED};
			5'd1:  w = '{SRC_CODE_RW, 1'b1, 1'b0, COND_NONE, '0};
			5'd2:  w = '{SRC_W1_HI, 1'b1, 1'b0, COND_NONE, '0};
			5'd3:  w = '{SRC_W1_LO, 1'b1, 1'b0, COND_NONE, '0};
			5'd4:  w = '{SRC_W2_HI, 1'b1, 1'b0, COND_NONE, '0};
			5'd5:  w = '{SRC_W2_LO, 1'b1, 1'b0, COND_NOT_WRITE, ADDR_CRC};
			5'd6:  w = '{SRC_D1_HI, 1'b1, 1'b0, COND_NONE, '0};
			5'd7:  w = '{SRC_D1_LO, 1'b1, 1'b0, COND_NONE, '0};
			5'd8:  w = '{SRC_D2_HI, 1'b1, 1'b0, COND_NONE, '0};
			5'd9:  w = '{SRC_D2_LO, 1'b1, 1'b0, COND_NONE, '0};
			5'd10: w = '{SRC_CRC_LO, 1'b0, 1'b0, COND_NONE, '0};
			5'd11: w = '{SRC_CRC_HI, 1'b0, 1'b1, COND_NONE, '0};
			5'd12: w = '{SRC_CODE_SP, 1'b1, 1'b0, COND_NONE, '0};
			5'd13: w = '{SRC_W1_LO, 1'b1, 1'b0, COND_NONE, '0};
			5'd14: w = '{SRC_W1_HI, 1'b1, 1'b0, COND_NONE, '0};
			5'd15: w = '{SRC_W2_LO, 1'b1, 1'b0, COND_NONE, '0};
			5'd16: w = '{SRC_W2_HI, 1'b1, 1'b0, COND_ALWAYS, ADDR_CRC};
			default: w = '{SRC_CRC_HI, 1'b0, 1'b1, COND_NONE, '0};
		endcase
		return w;
	endfunction

	// one byte through the reflected crc-16
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/dcfb_cmd_if.sv
// command channel interface
interface dcfb_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] first_word;
	logic [15:0] second_word;
	logic [15:0] first_data;
	logic [15:0] second_data;

	modport source (output valid, kind, first_word, second_word, first_data, second_data,
		input ready);
	modport sink (input valid, kind, first_word, second_word, first_data, second_data,
		output ready);
endinterface

### rtl/core/dcfb_byte_if.sv
// frame byte channel interface
interface dcfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_of_frame;

	modport source (output valid, frame_byte, last_of_frame, input ready);
	modport sink (input valid, frame_byte, last_of_frame, output ready);
endinterface

### rtl/core/dcfb_useq.sv
// microcode sequencer: step counter, control table and jumps
module dcfb_useq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                step_en,
	input  dcfb_pkg::stat_t                     stat,
	output logic                                busy,
	output logic [dcfb_pkg::ADDR_W-1:0]         step,
	output dcfb_pkg::ctl_t                      ctl
);

	logic                        busy_q;
	logic [dcfb_pkg::ADDR_W-1:0] step_q;
	logic [dcfb_pkg::ADDR_W-1:0] step_nxt;
	logic                        taken;

	assign ctl  = dcfb_pkg::ucode_rom(step_q);
	assign busy = busy_q;
	assign step = step_q;

	always_comb begin
		unique case (ctl.cond)
			dcfb_pkg::COND_SPEED:     taken = stat.is_speed;
			dcfb_pkg::COND_NOT_WRITE: taken = !stat.is_write;
			dcfb_pkg::COND_ALWAYS:    taken = 1'b1;
			default:                  taken = 1'b0;
		endcase
		step_nxt = taken ? ctl.target : step_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (step_en) begin
			if (ctl.last) begin
				busy_q <= 1'b0;
			end
			step_q <= step_nxt;
		end
	end

endmodule

### rtl/core/dcfb_dpath.sv
// datapath: command registers, byte select, crc register and output register
module dcfb_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [1:0]      kind,
	input  logic [15:0]     first_word,
	input  logic [15:0]     second_word,
	input  logic [15:0]     first_data,
	input  logic [15:0]     second_data,
	input  logic            step_en,
	input  dcfb_pkg::ctl_t  ctl,
	input  logic            out_ready,
	output dcfb_pkg::stat_t stat,
	output logic            out_free,
	output logic            out_valid,
	output logic [7:0]      frame_byte,
	output logic            last_of_frame
);

	logic [1:0]  kind_q;
	logic [15:0] w1_q;
	logic [15:0] w2_q;
	logic [15:0] d1_q;
	logic [15:0] d2_q;
	logic [15:0] crc_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        out_valid_q;
	logic [7:0]  byte_sel;

	always_comb begin
		case (ctl.src)
			dcfb_pkg::SRC_STATION: byte_sel = dcfb_pkg::STATION_ADDR;
			dcfb_pkg::SRC_CODE_RW: byte_sel = (kind_q == dcfb_pkg::KIND_WRITE) ?
				dcfb_pkg::CODE_WRITE : dcfb_pkg::CODE_READ;
			dcfb_pkg::SRC_CODE_SP: byte_sel = dcfb_pkg::CODE_SPEED;
			dcfb_pkg::SRC_W1_HI:   byte_sel = w1_q[15:8];
			dcfb_pkg::SRC_W1_LO:   byte_sel = w1_q[7:0];
			dcfb_pkg::SRC_W2_HI:   byte_sel = w2_q[15:8];
			dcfb_pkg::SRC_W2_LO:   byte_sel = w2_q[7:0];
			dcfb_pkg::SRC_D1_HI:   byte_sel = d1_q[15:8];
			dcfb_pkg::SRC_D1_LO:   byte_sel = d1_q[7:0];
			dcfb_pkg::SRC_D2_HI:   byte_sel = d2_q[15:8];
			dcfb_pkg::SRC_D2_LO:   byte_sel = d2_q[7:0];
			dcfb_pkg::SRC_CRC_LO:  byte_sel = crc_q[7:0];
			default:               byte_sel = crc_q[15:8];
		endcase
	end

	assign stat.is_speed = (kind_q == dcfb_pkg::KIND_SPEED);
	assign stat.is_write = (kind_q == dcfb_pkg::KIND_WRITE);
	assign out_free      = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign frame_byte    = byte_q;
	assign last_of_frame = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind;
			w1_q   <= first_word;
			w2_q   <= second_word;
			d1_q   <= first_data;
			d2_q   <= second_data;
			crc_q  <= dcfb_pkg::CRC_INIT;
		end else if (step_en && ctl.crc_upd) begin
			crc_q <= dcfb_pkg::crc_byte(crc_q, byte_sel);
		end
		if (step_en) begin
			byte_q <= byte_sel;
			last_q <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/drive_command_frame_builder_core.sv
// drive command frame builder top level
// first byte of a frame: the command item starts the sequencer, whose first step loads the output register
// throughput: one microcode step per cycle while the output register is free, one byte per step; 8 bytes per speed set
// or read item and 12 per write item, the next item taken in the cycle of the last byte
// reset: clears the step counter, busy flag and output valid; no memories to clear
module drive_command_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	dcfb_cmd_if.sink    cmd,
	dcfb_byte_if.source frame
);

	logic                        busy;
	logic                        out_free;
	logic                        fire;
	logic                        in_fire;
	logic [dcfb_pkg::ADDR_W-1:0] step;
	dcfb_pkg::ctl_t              ctl;
	dcfb_pkg::stat_t             stat;

	assign fire      = busy && out_free;
	assign cmd.ready = !busy || (fire && ctl.last);
	assign in_fire   = cmd.valid && cmd.ready;

	dcfb_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.step_en (fire),
		.stat    (stat),
		.busy    (busy),
		.step    (step),
		.ctl     (ctl)
	);

	dcfb_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (in_fire),
		.kind          (cmd.kind),
		.first_word    (cmd.first_word),
		.second_word   (cmd.second_word),
		.first_data    (cmd.first_data),
		.second_data   (cmd.second_data),
		.step_en       (fire),
		.ctl           (ctl),
		.out_ready     (frame.ready),
		.stat          (stat),
		.out_free      (out_free),
		.out_valid     (frame.valid),
		.frame_byte    (frame.frame_byte),
		.last_of_frame (frame.last_of_frame)
	);

`ifndef SYNTHESIS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy && step == '0)
		else $error("sequencer did not restart on a new item");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl.last && !in_fire |=> !busy)
		else $error("sequencer still busy after last byte");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> step <= dcfb_pkg::ADDR_LAST)
		else $error("step counter left the program");

	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> frame.valid && frame.last_of_frame == $past(ctl.last))
		else $error("stepped byte not presented");
`endif

endmodule
